FILE: hw/rtl/tpte_pkg.sv
// ----------------------------------------------------------------------------
// tpte_pkg
// Shared types and codes of the tile pixel transform engine: request and
// response payloads, operation and status codes, register indexes.
// ----------------------------------------------------------------------------
package tpte_pkg;

  localparam int OP_W       = 4;
  localparam int TILE_IDX_W = 4;
  localparam int POS_W      = 5;
  localparam int PIX_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;

  localparam logic [OP_W-1:0] OP_READ        = 4'd0;
  localparam logic [OP_W-1:0] OP_PLOT        = 4'd1;
  localparam logic [OP_W-1:0] OP_FILL        = 4'd2;
  localparam logic [OP_W-1:0] OP_REPLACE     = 4'd3;
  localparam logic [OP_W-1:0] OP_ROTATE      = 4'd4;
  localparam logic [OP_W-1:0] OP_MIRROR_ROWS = 4'd5;
  localparam logic [OP_W-1:0] OP_MIRROR_COLS = 4'd6;
  localparam logic [OP_W-1:0] OP_SHIFT_DOWN  = 4'd7;
  localparam logic [OP_W-1:0] OP_SHIFT_RIGHT = 4'd8;
  localparam logic [OP_W-1:0] OP_DIAG_UPPER  = 4'd9;
  localparam logic [OP_W-1:0] OP_DIAG_LOWER  = 4'd10;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_SQUARE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 6'd32;

  typedef struct packed {
    logic [OP_W-1:0]       operation;
    logic [TILE_IDX_W-1:0] tile_index;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic [PIX_W-1:0]      colour_a;
    logic [PIX_W-1:0]      colour_b;
  } req_t;

  typedef struct packed {
    logic [PIX_W-1:0]    pixel_value;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic            valid;
    logic [OP_W-1:0] operation;
  } xfer_t;

endpackage

FILE: hw/rtl/tpte_addr.sv
// ----------------------------------------------------------------------------
// tpte_addr
// Maps the pixel walk position to a source offset in the tile and a
// destination offset in the scratch tile, one pixel per cycle.
// ----------------------------------------------------------------------------
module tpte_addr import tpte_pkg::*; #(
  parameter int MAX_DIM = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  xfer_t                              ctl,
  input  logic [$clog2(MAX_DIM)-1:0]         cy,
  input  logic [$clog2(MAX_DIM)-1:0]         cx,
  input  logic [$clog2(MAX_DIM+1)-1:0]       w,
  input  logic [$clog2(MAX_DIM+1)-1:0]       h,
  output xfer_t                              s1,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_off,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] sc_off
);

  localparam int CW  = $clog2(MAX_DIM);
  localparam int DW  = $clog2(MAX_DIM+1);
  localparam int PW  = CW + DW;
  localparam int TAW = $clog2(MAX_DIM*MAX_DIM);

  logic [CW-1:0] xm, ym, xn, yn, lo, hi;
  logic [CW-1:0] rr, rc, wr, wc;
  logic [DW-1:0] stride;
  logic [PW-1:0] mr, mw;
  logic [CW-1:0] rc1, wc1;

  always_comb begin
    xm = CW'(w - DW'(1) - DW'(cx));
    ym = CW'(h - DW'(1) - DW'(cy));
    xn = (DW'(cx) == w - DW'(1)) ? '0 : cx + 1'b1;
    yn = (DW'(cy) == h - DW'(1)) ? '0 : cy + 1'b1;
    lo = (cx < cy) ? cx : cy;
    hi = (cx < cy) ? cy : cx;
    rr = cy;
    rc = cx;
    wr = cy;
    wc = cx;
    stride = w;
    unique case (ctl.operation)
      OP_ROTATE: begin
        wr = xm;
        wc = cy;
        stride = h;
      end
      OP_MIRROR_ROWS: wr = ym;
      OP_MIRROR_COLS: wc = xm;
      OP_SHIFT_DOWN:  wr = yn;
      OP_SHIFT_RIGHT: wc = xn;
      OP_DIAG_UPPER: begin
        rr = lo;
        rc = hi;
      end
      OP_DIAG_LOWER: begin
        rr = hi;
        rc = lo;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= ctl.valid;
    end
    s1.operation <= ctl.operation;
    mr  <= PW'(rr) * PW'(w);
    mw  <= PW'(wr) * PW'(stride);
    rc1 <= rc;
    wc1 <= wc;
  end

  assign rd_off = TAW'(mr + PW'(rc1));
  assign sc_off = TAW'(mw + PW'(wc1));

endmodule

FILE: hw/rtl/tpte_datapath.sv
// ----------------------------------------------------------------------------
// tpte_datapath
// Pixel store and scratch tile memories; read and plot use the store alone,
// other ops read the tile into scratch with the pixel update and copy back.
// ----------------------------------------------------------------------------
module tpte_datapath import tpte_pkg::*; #(
  parameter int NUM_TILES = 16,
  parameter int MAX_DIM   = 32
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  xfer_t                                        s1,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]           rd_off,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]           sc_off,
  input  logic [$clog2(NUM_TILES*MAX_DIM*MAX_DIM)-1:0] base,
  input  logic [PIX_W-1:0]                             colour_a,
  input  logic [PIX_W-1:0]                             colour_b,
  input  logic                                         cp_rd,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]           cp_idx,
  output xfer_t                                        s2,
  output logic [PIX_W-1:0]                             rdata,
  output logic                                         cp_busy
);

  localparam int TW  = MAX_DIM * MAX_DIM;
  localparam int TAW = $clog2(TW);
  localparam int SW  = NUM_TILES * TW;
  localparam int SAW = $clog2(SW);

  logic [PIX_W-1:0] store [SW];
  logic [PIX_W-1:0] scratch [TW];

  logic [SAW-1:0]   raddr, waddr, cp_addr;
  logic [PIX_W-1:0] wdata, cdata, pix;
  logic             we, cp_wr;
  logic [TAW-1:0]   sc2;

  assign raddr   = base + SAW'(rd_off);
  assign cp_busy = cp_wr;

  always_comb begin
    we    = 1'b0;
    waddr = raddr;
    wdata = colour_a;
    if (cp_wr) begin
      we    = 1'b1;
      waddr = cp_addr;
      wdata = cdata;
    end else if (s1.valid && s1.operation == OP_PLOT) begin
      we = 1'b1;
    end
  end

  always_comb begin
    priority if (s2.operation == OP_FILL) begin
      pix = colour_a;
    end else if (s2.operation == OP_REPLACE && rdata == colour_a) begin
      pix = colour_b;
    end else begin
      pix = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    if (s1.valid) begin
      rdata <= store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (s2.valid && s2.operation != OP_READ && s2.operation != OP_PLOT) begin
      scratch[sc2] <= pix;
    end
    if (cp_rd) begin
      cdata <= scratch[cp_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
      cp_wr    <= 1'b0;
    end else begin
      s2.valid <= s1.valid;
      cp_wr    <= cp_rd;
    end
    s2.operation <= s1.operation;
    sc2          <= sc_off;
    cp_addr      <= base + SAW'(cp_idx);
  end

endmodule

FILE: hw/rtl/tile_pixel_transform_engine_top.sv
// requests that fail the checks go straight to the result without a pass;
// whole-tile operations make one pass over the tile into the scratch tile
// and one pass copying it back, each one pixel per cycle; one request in
// flight at a time
// reset clears control state and sets the tile to 32 by 32; memories keep
// their contents
// ----------------------------------------------------------------------------
// tile_pixel_transform_engine_top
// Tile store with per-request pixel and whole-tile transform operations.
// ----------------------------------------------------------------------------
module tile_pixel_transform_engine_top import tpte_pkg::*; #(
  parameter int NUM_TILES = 16,
  parameter int MAX_DIM   = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  req_t                  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rsp_t                  out_data
);

  localparam int CW  = $clog2(MAX_DIM);
  localparam int DW  = $clog2(MAX_DIM+1);
  localparam int TW  = MAX_DIM * MAX_DIM;
  localparam int TAW = $clog2(TW);
  localparam int NW  = TAW + 1;
  localparam int SAW = $clog2(NUM_TILES * TW);
  localparam int MW  = TILE_IDX_W + NW;

  typedef enum logic [2:0] {
    IDLE, BASE, PASS1, DRAIN1, PASS2, DRAIN2, DONE
  } state_t;

  state_t                state;
  logic [CFG_DATA_W-1:0] tile_width, tile_height;
  logic [DW-1:0]         w, h;
  logic [NW-1:0]         n_reg;
  req_t                  req;
  rsp_t                  result;
  logic [STATUS_W-1:0]   in_err;
  logic [SAW-1:0]        base;
  logic [CW-1:0]         cy, cx;
  logic [TAW-1:0]        ci;
  logic                  single, last1, row_end, last2, cp_busy;
  xfer_t                 ctl, s1, s2;
  logic [TAW-1:0]        rd_off, sc_off;
  logic [PIX_W-1:0]      rdata;

  always_comb begin
    w = (tile_width == '0) ? DW'(1) :
        (32'(tile_width) > MAX_DIM) ? DW'(MAX_DIM) : DW'(tile_width);
    h = (tile_height == '0) ? DW'(1) :
        (32'(tile_height) > MAX_DIM) ? DW'(MAX_DIM) : DW'(tile_height);
  end

  always_comb begin
    priority if (in_data.operation > OP_DIAG_LOWER ||
                 32'(in_data.tile_index) >= NUM_TILES) begin
      in_err = ST_RANGE;
    end else if ((in_data.operation == OP_READ || in_data.operation == OP_PLOT) &&
                 (32'(in_data.pos_x) >= 32'(w) || 32'(in_data.pos_y) >= 32'(h))) begin
      in_err = ST_RANGE;
    end else if ((in_data.operation == OP_DIAG_UPPER ||
                  in_data.operation == OP_DIAG_LOWER) && w != h) begin
      in_err = ST_NOT_SQUARE;
    end else begin
      in_err = ST_OK;
    end
  end

  assign in_ready = (state == IDLE);
  assign single   = (req.operation == OP_READ || req.operation == OP_PLOT);
  assign row_end  = (DW'(cx) == w - DW'(1));
  assign last1    = single || (row_end && DW'(cy) == h - DW'(1));
  assign last2    = (NW'(ci) == n_reg - NW'(1));

  assign ctl.valid     = (state == PASS1);
  assign ctl.operation = req.operation;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      out_valid   <= 1'b0;
      tile_width  <= DIM_RESET;
      tile_height <= DIM_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TILE_WIDTH:  tile_width  <= cfg_data;
          REG_TILE_HEIGHT: tile_height <= cfg_data;
          default: ;
        endcase
      end
      n_reg <= NW'({DW'(0), w} * {DW'(0), h});
      if (out_valid && out_ready && state != DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            req                <= in_data;
            result.pixel_value <= '0;
            result.status      <= in_err;
            state              <= (in_err != ST_OK) ? DONE : BASE;
          end
        end
        BASE: begin
          base  <= SAW'(MW'(req.tile_index) * MW'(n_reg));
          cy    <= single ? CW'(req.pos_y) : '0;
          cx    <= single ? CW'(req.pos_x) : '0;
          state <= PASS1;
        end
        PASS1: begin
          if (last1) begin
            state <= DRAIN1;
          end else if (row_end) begin
            cx <= '0;
            cy <= cy + 1'b1;
          end else begin
            cx <= cx + 1'b1;
          end
        end
        DRAIN1: begin
          if (!s1.valid && !s2.valid) begin
            ci    <= '0;
            state <= single ? DONE : PASS2;
          end
        end
        PASS2: begin
          if (last2) begin
            state <= DRAIN2;
          end else begin
            ci <= ci + 1'b1;
          end
        end
        DRAIN2: begin
          if (!cp_busy) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= result;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if (s2.valid && s2.operation == OP_READ) begin
        result.pixel_value <= rdata;
      end
    end
  end

  tpte_addr #(
    .MAX_DIM (MAX_DIM)
  ) u_addr (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .cy     (cy),
    .cx     (cx),
    .w      (w),
    .h      (h),
    .s1     (s1),
    .rd_off (rd_off),
    .sc_off (sc_off)
  );

  tpte_datapath #(
    .NUM_TILES (NUM_TILES),
    .MAX_DIM   (MAX_DIM)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s1       (s1),
    .rd_off   (rd_off),
    .sc_off   (sc_off),
    .base     (base),
    .colour_a (req.colour_a),
    .colour_b (req.colour_b),
    .cp_rd    (state == PASS2),
    .cp_idx   (ci),
    .s2       (s2),
    .rdata    (rdata),
    .cp_busy  (cp_busy)
  );

endmodule

FILE: hw/rtl/tpte_checker.sv
// ----------------------------------------------------------------------------
// tpte_checker
// Port-level checks of the tile pixel transform engine, bound to the top.
// ----------------------------------------------------------------------------
module tpte_checker import tpte_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data,
  input logic                  in_valid,
  input logic                  in_ready,
  input req_t                  in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input rsp_t                  out_data
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request in flight
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_RANGE ||
                   out_data.status == ST_NOT_SQUARE))
    else $error("bad status code");

  // failed requests return no pixel
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.pixel_value == '0)
    else $error("pixel on failed request");

endmodule

bind tile_pixel_transform_engine_top tpte_checker u_tpte_checker (.*);
